/* rtl/core/tmtt_pkg.sv */
// Shared types and constants for the tempo map tick-to-time block.
package tmtt_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int TICK_W  = 31;
   localparam int TEMPO_W = 16;
   localparam int TIME_W  = 48;

   // 8192000 = 125 << 16
   localparam int SCALE_MUL   = 125;
   localparam int SCALE_SHIFT = 16;
   localparam int PROD_W      = TICK_W + 7;
   localparam int DIVD_W      = PROD_W + SCALE_SHIFT;
   localparam int STEP_W      = $clog2(DIVD_W);

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;
   localparam logic [1:0] ST_SAT  = 2'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic [TICK_W-1:0]  tick;
      logic [TEMPO_W-1:0] tempo;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_value;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0]  position;
      logic [TEMPO_W-1:0] tempo;
   } entry_type;

endpackage

/* rtl/core/tempo_map_tick_to_time.sv */
// Tempo map: sorted tempo table in a RAM, clear, insert and tick-to-time query.
//
//  channel | dir | handshake             | payload
//  req_    | in  | req_valid / req_stall | req_data    (operation, tick, tempo)
//  rsp_    | out | rsp_valid / rsp_stall | rsp_data    (time_value, status)
//  csr_    | in  | csr_valid / csr_ready | csr_data    (default_tempo)
//
// Clear, rejected inserts, unknown ops and inserts into an empty table go to S_RESP.
// Insert: moves each entry above the new tick up a slot, then writes the new entry.
// Query: reads the entries in order, summing a segment per tempo span plus the tail;
//   each segment uses the bit-serial 54-bit by 16-bit divider, one quotient bit a cycle.
// One request at a time; req_stall is high from acceptance until the response
//   is loaded into the output register, which holds under rsp_stall.
// Synchronous reset empties the table and restores default_tempo to 7680;
//   table RAM contents are not cleared, only entries below the count are read.
module tempo_map_tick_to_time
   import tmtt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [TEMPO_W-1:0]  csr_data
);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_INS_RD  = 10'b0000000010,
      S_INS_CHK = 10'b0000000100,
      S_Q_RD    = 10'b0000001000,
      S_Q_CHK   = 10'b0000010000,
      S_SEG_MUL = 10'b0000100000,
      S_SEG_DIV = 10'b0001000000,
      S_SEG_ADD = 10'b0010000000,
      S_Q_FIN   = 10'b0100000000,
      S_RESP    = 10'b1000000000
   } state_type;

   // table RAM, one read port (registered), one write port
   entry_type             mem [MAX_ENTRIES];
   logic [IDX_W-1:0]      rd_addr;
   entry_type             rd_data_ff;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TEMPO_W-1:0]    dflt_ff, dflt_in;
   req_type               req_ff, req_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [TICK_W-1:0]     cursor_ff, cursor_in;
   logic [TEMPO_W-1:0]    cur_ff, cur_in;
   logic [TEMPO_W-1:0]    pend_ff, pend_in;
   logic [TICK_W-1:0]     seg_ticks_ff, seg_ticks_in;
   logic [TEMPO_W-1:0]    divisor_ff, divisor_in;
   logic                  seg_last_ff, seg_last_in;
   logic [DIVD_W-1:0]     quo_ff, quo_in;
   logic [TEMPO_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [TIME_W-1:0]     acc_ff, acc_in;
   logic                  sat_ff, sat_in;
   logic                  is_query_ff, is_query_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  req_take;
   logic [TEMPO_W:0]      trial;
   logic [TEMPO_W:0]      trial_sub;
   logic [PROD_W-1:0]     prod;
   logic [DIVD_W:0]       sum;
   logic [TEMPO_W-1:0]    eff_cur;
   logic [CNT_W-1:0]      idx_nxt;
   logic [CNT_W-1:0]      idx_dec;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // one divider step: shift in next dividend bit, subtract if it fits
   assign trial     = {rem_ff, quo_ff[DIVD_W-1]};
   assign trial_sub = trial - {1'b0, divisor_ff};
   assign prod      = PROD_W'(seg_ticks_ff) * PROD_W'(SCALE_MUL);
   assign sum       = (DIVD_W+1)'(acc_ff) + (DIVD_W+1)'(quo_ff);
   // first entry seeds the running tempo
   assign eff_cur   = (idx_ff == '0) ? rd_data_ff.tempo : cur_ff;
   assign idx_nxt   = idx_ff + CNT_W'(1);
   assign idx_dec   = idx_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dflt_in       = dflt_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      cursor_in     = cursor_ff;
      cur_in        = cur_ff;
      pend_in       = pend_ff;
      seg_ticks_in  = seg_ticks_ff;
      divisor_in    = divisor_ff;
      seg_last_in   = seg_last_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      sat_in        = sat_ff;
      is_query_in   = is_query_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      rd_addr       = idx_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_data       = rd_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         dflt_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               req_in        = req_data;
               is_query_in   = 1'b0;
               res_status_in = ST_OK;
               acc_in        = '0;
               sat_in        = 1'b0;
               cursor_in     = '0;
               idx_in        = '0;
               state_in      = S_RESP;
               case (req_data.operation)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_INSERT: begin
                     if (req_data.tempo == '0) begin
                        res_status_in = ST_ZERO;
                     end else if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        idx_in = count_ff;
                        if (count_ff == '0) begin
                           wr_en    = 1'b1;
                           wr_addr  = '0;
                           wr_data  = '{position: req_data.tick, tempo: req_data.tempo};
                           count_in = CNT_W'(1);
                        end else begin
                           state_in = S_INS_RD;
                        end
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        if (dflt_ff == '0) begin
                           res_status_in = ST_ZERO;
                        end else begin
                           is_query_in = 1'b1;
                           cur_in      = dflt_ff;
                           state_in    = S_Q_FIN;
                        end
                     end else begin
                        is_query_in = 1'b1;
                        state_in    = S_Q_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS_RD: begin
            rd_addr  = idx_dec[IDX_W-1:0];
            state_in = S_INS_CHK;
         end
         S_INS_CHK: begin
            wr_en = 1'b1;
            if (rd_data_ff.position > req_ff.tick) begin
               wr_data = rd_data_ff;
               idx_in  = idx_dec;
               if (idx_dec == '0) begin
                  state_in = S_INS_RD;
                  // slot 0 is free: place the new entry next cycle via INS_CHK
               end
               state_in = S_INS_RD;
               if (idx_dec == '0) begin
                  state_in = S_INS_CHK;
               end
            end else begin
               wr_data  = '{position: req_ff.tick, tempo: req_ff.tempo};
               count_in = count_ff + CNT_W'(1);
               state_in = S_RESP;
            end
            // reaching slot 0: rd_data is stale, force the new entry in
            if (idx_ff == '0) begin
               wr_data  = '{position: req_ff.tick, tempo: req_ff.tempo};
               idx_in   = idx_ff;
               count_in = count_ff + CNT_W'(1);
               state_in = S_RESP;
            end
         end
         S_Q_RD: begin
            state_in = S_Q_CHK;
         end
         S_Q_CHK: begin
            if (rd_data_ff.position <= cursor_ff) begin
               cur_in   = rd_data_ff.tempo;
               idx_in   = idx_nxt;
               state_in = (idx_nxt == count_ff) ? S_Q_FIN : S_Q_RD;
            end else if (rd_data_ff.position >= req_ff.tick) begin
               cur_in   = eff_cur;
               state_in = S_Q_FIN;
            end else begin
               seg_ticks_in = rd_data_ff.position - cursor_ff;
               divisor_in   = eff_cur;
               cursor_in    = rd_data_ff.position;
               pend_in      = rd_data_ff.tempo;
               seg_last_in  = 1'b0;
               state_in     = S_SEG_MUL;
            end
         end
         S_SEG_MUL: begin
            quo_in   = {prod, {SCALE_SHIFT{1'b0}}};
            rem_in   = '0;
            step_in  = '0;
            state_in = S_SEG_DIV;
         end
         S_SEG_DIV: begin
            if (!trial_sub[TEMPO_W]) begin
               rem_in = trial_sub[TEMPO_W-1:0];
               quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[TEMPO_W-1:0];
               quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIVD_W - 1)) begin
               state_in = S_SEG_ADD;
            end
         end
         S_SEG_ADD: begin
            acc_in = sum[TIME_W-1:0];
            if (sum[DIVD_W:TIME_W] != '0) begin
               sat_in = 1'b1;
            end
            if (seg_last_ff) begin
               state_in = S_RESP;
            end else begin
               cur_in   = pend_ff;
               idx_in   = idx_nxt;
               state_in = (idx_nxt == count_ff) ? S_Q_FIN : S_Q_RD;
            end
         end
         S_Q_FIN: begin
            if (req_ff.tick > cursor_ff) begin
               seg_ticks_in = req_ff.tick - cursor_ff;
               divisor_in   = cur_ff;
               seg_last_in  = 1'b1;
               state_in     = S_SEG_MUL;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (is_query_ff) begin
                  rsp_in.time_value = sat_ff ? TIME_MAX : acc_ff;
                  rsp_in.status     = sat_ff ? ST_SAT : ST_OK;
               end else begin
                  rsp_in.time_value = '0;
                  rsp_in.status     = res_status_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dflt_ff      <= TEMPO_W'(7680);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dflt_ff      <= dflt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      cursor_ff     <= cursor_in;
      cur_ff        <= cur_in;
      pend_ff       <= pend_in;
      seg_ticks_ff  <= seg_ticks_in;
      divisor_ff    <= divisor_in;
      seg_last_ff   <= seg_last_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      acc_ff        <= acc_in;
      sat_ff        <= sat_in;
      is_query_ff   <= is_query_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   // table RAM
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEG_DIV |-> divisor_ff != '0)
      else $error("segment divide by zero tempo");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_SAT |-> rsp_ff.time_value == TIME_MAX)
      else $error("saturated response without full-scale time");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

endmodule

/* tb/tempo_map_checker.sv */
// Checker for the tempo map block: tracks requests, predicts responses and compares them.
`timescale 1ns / 1ps
module tempo_map_checker
   import tmtt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  rsp_type            rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [TEMPO_W-1:0] csr_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 query_count,
   output int                 sat_count
);

   logic [TICK_W-1:0]  tbl_pos [MAX_ENTRIES];
   logic [TEMPO_W-1:0] tbl_tempo [MAX_ENTRIES];
   int                 tbl_count;
   logic [TEMPO_W-1:0] dflt_tempo;
   rsp_type            expected_rsps [$];
   int                 mismatch_count;

   function automatic logic [63:0] segment_time(logic [TICK_W-1:0] ticks,
                                                logic [TEMPO_W-1:0] tempo);
      return (64'(ticks) * 64'd8192000) / 64'(tempo);
   endfunction

   function automatic rsp_type tempo_map_predict(req_type r);
      rsp_type            o;
      logic [63:0]        total;
      logic [TICK_W-1:0]  cursor;
      logic [TEMPO_W-1:0] cur;
      int                 i;
      o = '0;
      total = 0;
      cursor = 0;
      case (r.operation)
         OP_CLEAR: tbl_count = 0;
         OP_INSERT: begin
            if (r.tempo == 0) o.status = ST_ZERO;
            else if (tbl_count >= MAX_ENTRIES) o.status = ST_FULL;
            else begin
               i = tbl_count;
               while (i > 0 && tbl_pos[i-1] > r.tick) begin
                  tbl_pos[i] = tbl_pos[i-1];
                  tbl_tempo[i] = tbl_tempo[i-1];
                  i--;
               end
               tbl_pos[i] = r.tick;
               tbl_tempo[i] = r.tempo;
               tbl_count++;
            end
         end
         OP_QUERY: begin
            if (tbl_count == 0 && dflt_tempo == 0) begin
               o.status = ST_ZERO;
               return o;
            end
            cur = (tbl_count == 0) ? dflt_tempo : tbl_tempo[0];
            for (i = 0; i < tbl_count; i++) begin
               if (tbl_pos[i] <= cursor) begin
                  cur = tbl_tempo[i];
                  continue;
               end
               if (tbl_pos[i] >= r.tick) break;
               total += segment_time(tbl_pos[i] - cursor, cur);
               cursor = tbl_pos[i];
               cur = tbl_tempo[i];
            end
            if (r.tick > cursor) total += segment_time(r.tick - cursor, cur);
            if (total > 64'(TIME_MAX)) begin
               o.time_value = TIME_MAX;
               o.status = ST_SAT;
            end else o.time_value = total[TIME_W-1:0];
         end
         default: ;
      endcase
      return o;
   endfunction

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         tbl_count = 0;
         dflt_tempo <= 16'd7680;
         fail_count <= 0;
         mismatch_count = 0;
         query_count <= 0;
         sat_count <= 0;
         expected_rsps.delete();
      end else begin
         if (csr_valid && csr_ready) dflt_tempo <= csr_data;
         if (req_valid && !req_stall) begin
            expected_rsps = {expected_rsps, tempo_map_predict(req_data)};
            if (req_data.operation == OP_QUERY) query_count <= query_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               fail_count <= fail_count + 1;
               if (mismatch_count < 10) $display("unexpected response %h", rsp_data);
               mismatch_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (want.status == ST_SAT) sat_count <= sat_count + 1;
               if (want.time_value !== rsp_data.time_value ||
                   want.status !== rsp_data.status) begin
                  fail_count <= fail_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch: time exp %0d got %0d, status exp %0d got %0d",
                              want.time_value, rsp_data.time_value,
                              want.status, rsp_data.status);
                  mismatch_count++;
               end
            end
         end
      end
   end

endmodule

/* tb/tb_tempo_map_tick_to_time.sv */
// Testbench top for the tempo map block: stimulus, idling, pressure and verdict.
`timescale 1ns / 1ps
module tb_tempo_map_tick_to_time;
   import tmtt_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   rsp_type            rsp_data;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [TEMPO_W-1:0] csr_data = '0;
   int                 fail_count, pending_count, query_count, sat_count;
   int                 cycle_count = 0;
   int                 sent_count = 0;
   bit                 hold_off = 0;   // long receiver stall request
   bit                 gaps_on = 1;    // receiver idling enabled

   always #6 clock = ~clock;

   tempo_map_tick_to_time dut (.*);

   tempo_map_checker u_checker (.*);

   // watchdog: ends the run as failed when the cycle count passes its limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 40000000) begin
         $display("timeout");
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stall per response, plus a long hold-off on demand
   initial begin
      int w;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
            rsp_stall <= 0;
         end else if (gaps_on && rsp_valid && !rsp_stall) begin
            w = $urandom_range(0, 14);
            if (w > 0 && ($urandom_range(0, 3) != 0)) begin
               rsp_stall <= 1;
               repeat (w) @(posedge clock);
               rsp_stall <= 0;
            end
         end
      end
   end

   // offer one request and wait for acceptance; valid stays up for a next
   // request offered straight away
   task automatic send_request(logic [1:0] op, logic [TICK_W-1:0] tk,
                               logic [TEMPO_W-1:0] tp, bit idle);
      int w;
      w = idle ? $urandom_range(0, 14) : 0;
      if ($urandom_range(0, 2) == 0) w = 0;
      if (w > 0) begin
         req_valid <= 0;
         repeat (w) @(posedge clock);
      end
      req_data  <= '{operation: op, tick: tk, tempo: tp};
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic drain_responses();
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_default(logic [TEMPO_W-1:0] v);
      drain_responses();
      csr_data  <= v;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   function automatic logic [TICK_W-1:0] rand_tick();
      case ($urandom_range(0, 3))
         0: return TICK_W'($urandom_range(0, 2000));
         1: return TICK_W'($urandom_range(0, 200000));
         2: return TICK_W'($urandom);
         default: return {TICK_W{1'b1}} - TICK_W'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [TEMPO_W-1:0] rand_tempo();
      case ($urandom_range(0, 3))
         0: return TEMPO_W'($urandom_range(1, 3));
         1: return TEMPO_W'($urandom_range(3000, 15000));
         default: return TEMPO_W'($urandom);
      endcase
   endfunction

   initial begin
      int n, k, len;
      int next_cfg, next_drain;
      bit held;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty table, extremes, zero tempo, saturation, unknown op, full table
      send_request(OP_QUERY, 0, 0, 0);
      send_request(OP_QUERY, {TICK_W{1'b1}}, 16'hffff, 0);
      send_request(OP_INSERT, 100, 0, 0);
      send_request(OP_INSERT, 0, 16'd1, 0);
      send_request(OP_QUERY, {TICK_W{1'b1}}, 0, 0);
      send_request(OP_INSERT, 480, 16'hffff, 0);
      send_request(OP_INSERT, 480, 16'd7680, 0);
      send_request(OP_INSERT, 200, 16'd3840, 0);
      send_request(OP_QUERY, 480, 0, 0);
      send_request(OP_QUERY, 1000, 0, 0);
      send_request(2'd3, {TICK_W{1'b1}}, 16'hffff, 0);
      send_request(OP_CLEAR, 5, 5, 0);
      write_default(16'd0);
      send_request(OP_QUERY, 1234, 0, 0);
      write_default(16'hffff);
      send_request(OP_QUERY, {TICK_W{1'b1}}, 0, 0);
      for (k = 0; k < MAX_ENTRIES + 2; k++)
         send_request(OP_INSERT, TICK_W'(k * 37 % 50), 16'(k + 1), 0);
      send_request(OP_QUERY, 60, 0, 0);
      send_request(OP_CLEAR, 0, 0, 0);
      write_default(16'd64);
      send_request(OP_QUERY, 9600, 0, 0);

      // random: mostly small tables built up then queried, some noise
      n = 0;
      next_cfg = 250;
      next_drain = 100;
      held = 0;
      while (n < 1950) begin
         if (!held && n >= 600) begin
            held = 1;
            hold_off = 1;   // block fills and stalls its input meanwhile
            send_request(OP_CLEAR, 0, 0, 0);
            for (k = 0; k < 6; k++) send_request(OP_QUERY, rand_tick(), 0, 0);
            n += 7;
         end
         if (n >= next_cfg) begin
            write_default(($urandom_range(0, 1)) ? 16'($urandom) : 16'd7680);
            next_cfg += 500;
         end
         if (n >= next_drain) begin
            drain_responses();   // sender pause until empty
            next_drain += 400;
         end
         gaps_on = (n % 300) > 60;
         send_request(OP_CLEAR, TICK_W'($urandom), TEMPO_W'($urandom), 1);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 8);
         for (k = 0; k < len; k++) begin
            send_request($urandom_range(0, 9) == 0 ? 2'($urandom) : OP_INSERT,
                         rand_tick(), ($urandom_range(0, 15) == 0) ? 16'd0 : rand_tempo(),
                         1);
            n++;
         end
         for (k = 0; k < $urandom_range(1, 4); k++) begin
            send_request(OP_QUERY, rand_tick(), TEMPO_W'($urandom), 1);
            n++;
         end
         n++;
      end
      write_default(16'd7680);
      send_request(OP_QUERY, 480, 0, 0);

      drain_responses();
      repeat (200) @(posedge clock);
      $display("Run covered %0d requests, %0d queries, %0d saturated results.",
               sent_count, query_count, sat_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
